// ----- design/stx_pkg.sv -----
// Shared types, constants and the gamma table for the sRGB to XYZ converter.
// Used by stx_linearize, stx_matrix and srgb_to_xyz_converter_unit.
`timescale 1ns / 1ps
`default_nettype none

package stx_pkg;

    // Linear channel value: L * 65536 on the 0..100 scale, max 6553600.
    localparam int LIN_W = 23;
    // Weighted row sum plus rounding offset, max about 7.14e10 on the Z row.
    localparam int SUM_W = 37;
    localparam int COEF_W = 14;
    localparam int OUT_W = 16;
    localparam int BYTE_W = 8;

    // Row sum is divided by 1280000 = 2048 * 625, rounded half up.
    localparam logic [SUM_W-1:0] ROUND_OFS = SUM_W'(640000);
    localparam int QUO_SHIFT = 11;
    localparam int QUO_W = SUM_W - QUO_SHIFT;
    // Reciprocal of 625 scaled by 2^35; exact for any quotient below 2^26.
    localparam int RECIP_SHIFT = 35;
    localparam int RECIP_W = 26;
    localparam logic [RECIP_W-1:0] RECIP_625 = RECIP_W'(54975582);
    localparam int PROD_W = QUO_W + RECIP_W;

    typedef logic [LIN_W-1:0] t_lin;
    typedef logic [2:0][LIN_W-1:0] t_lin_vec;
    typedef logic [LIN_W-1:0] t_lin_table [256];
    typedef logic [COEF_W-1:0] t_coef_row [3];
    typedef t_coef_row t_coef_mat [3];

    // Pipeline sideband: transfer marker and the alpha byte riding along.
    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] alpha;
    } t_side;

    // D65 matrix in ten-thousandths; rows X, Y, Z, columns R, G, B.
    localparam t_coef_mat MAT_K = '{
        '{COEF_W'(4124), COEF_W'(3576), COEF_W'(1805)},
        '{COEF_W'(2126), COEF_W'(7152), COEF_W'(722)},
        '{COEF_W'(193),  COEF_W'(1192), COEF_W'(9505)}
    };

    localparam logic [63:0] Q30_ONE  = 64'd1 << 30;
    localparam logic [63:0] Q30_HALF = 64'd1 << 29;

    function automatic logic [63:0] q30_mul(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] p;
        p = a * b;
        return p >> 30;
    endfunction

    function automatic logic [63:0] q30_pow5(input logic [63:0] v);
        logic [63:0] p;
        p = q30_mul(v, v);
        p = q30_mul(p, v);
        p = q30_mul(p, v);
        return q30_mul(p, v);
    endfunction

    // Evaluated once at elaboration: linear segment below code 11,
    // power 2.4 segment (t^2 times fifth root of t^2) from code 11 up.
    function automatic t_lin_table build_lin_table();
        t_lin_table  tab;
        logic [63:0] c;
        logic [63:0] n;
        logic [63:0] t;
        logic [63:0] t2;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mid;
        logic [63:0] l30;
        for (int i = 0; i < 256; i++) begin
            c = 64'(i);
            if (c <= 64'd10) begin
                tab[i] = LIN_W'((64'd131072000 * c + 64'd32946) / 64'd65892);
            end else begin
                n  = 64'd1000 * c + 64'd14025;
                t  = (64'd2 * (n << 30) + 64'd269025) / 64'd538050;
                t2 = (t * t + Q30_HALF) >> 30;
                lo = 64'd0;
                hi = Q30_ONE + 64'd1;
                for (int k = 0; k < 32; k++) begin
                    if (hi - lo > 64'd1) begin
                        mid = (lo + hi) >> 1;
                        if (q30_pow5(mid) <= t2) begin
                            lo = mid;
                        end else begin
                            hi = mid;
                        end
                    end
                end
                l30    = (t2 * lo + Q30_HALF) >> 30;
                tab[i] = LIN_W'((l30 * 64'd6553600 + Q30_HALF) >> 30);
            end
        end
        return tab;
    endfunction

    localparam t_lin_table LIN_TABLE = build_lin_table();

endpackage

`default_nettype wire

// ----- design/srgb_to_xyz_converter_unit.sv -----
// Top level of the sRGB to CIE XYZ (D65) converter: input register, gamma stage,
// matrix stage. Depends on stx_pkg, stx_linearize and stx_matrix.
//
//   channel  | handshake          | payload
//   ---------+--------------------+------------------------------------------
//   input    | start, busy        | i_red, i_green, i_blue, i_alpha_in
//   result   | o_valid (strobe)   | o_x_out, o_y_out, o_z_out, o_alpha_out
//
// One pixel per clock; busy is always low. After the input register, each result
// passes the table read, the row sums and the reciprocal scaling, one register each.
// Synchronous active-low reset clears the valid pipeline only; no clearing pass.
// The receiver cannot stall, so the pipeline never holds.
`timescale 1ns / 1ps
`default_nettype none

module srgb_to_xyz_converter_unit (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       start,
    output logic                            busy,
    input  wire logic [stx_pkg::BYTE_W-1:0] i_red,
    input  wire logic [stx_pkg::BYTE_W-1:0] i_green,
    input  wire logic [stx_pkg::BYTE_W-1:0] i_blue,
    input  wire logic [stx_pkg::BYTE_W-1:0] i_alpha_in,
    output logic                            o_valid,
    output logic [stx_pkg::OUT_W-1:0]       o_x_out,
    output logic [stx_pkg::OUT_W-1:0]       o_y_out,
    output logic [stx_pkg::OUT_W-1:0]       o_z_out,
    output logic [stx_pkg::BYTE_W-1:0]      o_alpha_out
);

    logic                       r_in_valid;
    logic [stx_pkg::BYTE_W-1:0] r_red;
    logic [stx_pkg::BYTE_W-1:0] r_green;
    logic [stx_pkg::BYTE_W-1:0] r_blue;
    logic [stx_pkg::BYTE_W-1:0] r_alpha;

    stx_pkg::t_side    in_side;
    stx_pkg::t_side    lin_side;
    stx_pkg::t_side    out_side;
    stx_pkg::t_lin_vec lin;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_red   <= i_red;
        r_green <= i_green;
        r_blue  <= i_blue;
        r_alpha <= i_alpha_in;
    end

    assign in_side.valid = r_in_valid;
    assign in_side.alpha = r_alpha;

    stx_linearize u_linearize (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_red   (r_red),
        .i_green (r_green),
        .i_blue  (r_blue),
        .i_side  (in_side),
        .o_lin   (lin),
        .o_side  (lin_side)
    );

    stx_matrix u_matrix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_lin   (lin),
        .i_side  (lin_side),
        .o_x     (o_x_out),
        .o_y     (o_y_out),
        .o_z     (o_z_out),
        .o_side  (out_side)
    );

    assign o_valid     = out_side.valid;
    assign o_alpha_out = out_side.alpha;

endmodule

`default_nettype wire

// ----- design/stx_linearize.sv -----
// Gamma decode stage: three reads of the constant table, registered.
// Depends on stx_pkg.
`timescale 1ns / 1ps
`default_nettype none

module stx_linearize (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic [stx_pkg::BYTE_W-1:0] i_red,
    input  wire logic [stx_pkg::BYTE_W-1:0] i_green,
    input  wire logic [stx_pkg::BYTE_W-1:0] i_blue,
    input  wire stx_pkg::t_side            i_side,
    output stx_pkg::t_lin_vec              o_lin,
    output stx_pkg::t_side                 o_side
);

    stx_pkg::t_lin_vec r_lin;
    stx_pkg::t_lin_vec n_lin;
    logic              r_valid;
    logic [stx_pkg::BYTE_W-1:0] r_alpha;

    always_comb begin
        n_lin[0] = stx_pkg::LIN_TABLE[i_red];
        n_lin[1] = stx_pkg::LIN_TABLE[i_green];
        n_lin[2] = stx_pkg::LIN_TABLE[i_blue];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_side.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lin   <= n_lin;
        r_alpha <= i_side.alpha;
    end

    assign o_lin        = r_lin;
    assign o_side.valid = r_valid;
    assign o_side.alpha = r_alpha;

endmodule

`default_nettype wire

// ----- design/stx_matrix.sv -----
// D65 matrix, rounding and scaling to 9 fraction bits, over two registered stages.
// Depends on stx_pkg.
`timescale 1ns / 1ps
`default_nettype none

module stx_matrix (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire stx_pkg::t_lin_vec         i_lin,
    input  wire stx_pkg::t_side            i_side,
    output logic [stx_pkg::OUT_W-1:0]      o_x,
    output logic [stx_pkg::OUT_W-1:0]      o_y,
    output logic [stx_pkg::OUT_W-1:0]      o_z,
    output stx_pkg::t_side                 o_side
);

    logic [stx_pkg::SUM_W-1:0]  r_sum [3];
    logic [stx_pkg::SUM_W-1:0]  n_sum [3];
    logic                       r_sum_valid;
    logic [stx_pkg::BYTE_W-1:0] r_sum_alpha;

    logic [stx_pkg::OUT_W-1:0]  r_out [3];
    logic [stx_pkg::OUT_W-1:0]  n_out [3];
    logic                       r_out_valid;
    logic [stx_pkg::BYTE_W-1:0] r_out_alpha;

    logic [stx_pkg::QUO_W-1:0]  quo  [3];
    logic [stx_pkg::PROD_W-1:0] prod [3];

    // Weighted sums with the half-divisor folded in for round half up.
    always_comb begin
        for (int row = 0; row < 3; row++) begin
            n_sum[row] = stx_pkg::ROUND_OFS;
            for (int col = 0; col < 3; col++) begin
                n_sum[row] = n_sum[row]
                    + stx_pkg::SUM_W'(i_lin[col]) * stx_pkg::SUM_W'(stx_pkg::MAT_K[row][col]);
            end
        end
    end

    // Divide by 1280000: drop 11 bits, then multiply by the reciprocal of 625.
    // The quotient stays below 2^16, so no saturation is ever reached.
    always_comb begin
        for (int row = 0; row < 3; row++) begin
            quo[row]   = r_sum[row][stx_pkg::SUM_W-1:stx_pkg::QUO_SHIFT];
            prod[row]  = stx_pkg::PROD_W'(quo[row]) * stx_pkg::PROD_W'(stx_pkg::RECIP_625);
            n_out[row] = prod[row][stx_pkg::RECIP_SHIFT +: stx_pkg::OUT_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_sum_valid <= i_side.valid;
            r_out_valid <= r_sum_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sum       <= n_sum;
        r_sum_alpha <= i_side.alpha;
        r_out       <= n_out;
        r_out_alpha <= r_sum_alpha;
    end

    assign o_x          = r_out[0];
    assign o_y          = r_out[1];
    assign o_z          = r_out[2];
    assign o_side.valid = r_out_valid;
    assign o_side.alpha = r_out_alpha;

endmodule

`default_nettype wire

// ----- tb/sv/xyz_pixel_checker.sv -----
// Checker for the sRGB to XYZ converter: watches the pixel and result channels,
// predicts X, Y, Z and alpha for each pixel transfer and compares in order.
// Depends on stx_pkg for field widths only.
`timescale 1ns / 1ps

module xyz_pixel_checker (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic                       i_busy,
    input  wire logic [stx_pkg::BYTE_W-1:0] i_red,
    input  wire logic [stx_pkg::BYTE_W-1:0] i_green,
    input  wire logic [stx_pkg::BYTE_W-1:0] i_blue,
    input  wire logic [stx_pkg::BYTE_W-1:0] i_alpha_in,
    input  wire logic                       i_valid,
    input  wire logic [stx_pkg::OUT_W-1:0]  i_x_out,
    input  wire logic [stx_pkg::OUT_W-1:0]  i_y_out,
    input  wire logic [stx_pkg::OUT_W-1:0]  i_z_out,
    input  wire logic [stx_pkg::BYTE_W-1:0] i_alpha_out,
    output int                              o_err_count,
    output int                              o_pending
);

    typedef struct packed {
        logic [stx_pkg::OUT_W-1:0]  x;
        logic [stx_pkg::OUT_W-1:0]  y;
        logic [stx_pkg::OUT_W-1:0]  z;
        logic [stx_pkg::BYTE_W-1:0] alpha;
    } xyz_px_t;

    localparam logic [63:0] ONE_Q30  = 64'd1 << 30;
    localparam logic [63:0] HALF_Q30 = 64'd1 << 29;

    // D65 rows X, Y, Z in ten-thousandths
    localparam logic [63:0] KX_R = 64'd4124, KX_G = 64'd3576, KX_B = 64'd1805;
    localparam logic [63:0] KY_R = 64'd2126, KY_G = 64'd7152, KY_B = 64'd722;
    localparam logic [63:0] KZ_R = 64'd193,  KZ_G = 64'd1192, KZ_B = 64'd9505;

    logic [stx_pkg::LIN_W-1:0] gamma_lut [256];
    xyz_px_t                   xyz_expected [$];

    function automatic logic [63:0] fx_mul(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] prod;
        prod = a * b;
        return prod >> 30;
    endfunction

    function automatic logic [63:0] fx_fifth(input logic [63:0] v);
        logic [63:0] acc;
        acc = fx_mul(v, v);
        acc = fx_mul(acc, v);
        acc = fx_mul(acc, v);
        return fx_mul(acc, v);
    endfunction

    // Linear value times 65536 on the 0..100 scale for one gamma code.
    function automatic logic [stx_pkg::LIN_W-1:0] linear_of_code(input int code);
        logic [63:0] cv;
        logic [63:0] num;
        logic [63:0] base;
        logic [63:0] sq;
        logic [63:0] lo_r;
        logic [63:0] hi_r;
        logic [63:0] probe;
        logic [63:0] l30;
        cv = 64'(code);
        if (cv <= 64'd10) begin
            return stx_pkg::LIN_W'((64'd131072000 * cv + 64'd32946) / 64'd65892);
        end
        num  = 64'd1000 * cv + 64'd14025;
        base = (64'd2 * (num << 30) + 64'd269025) / 64'd538050;
        sq   = (base * base + HALF_Q30) >> 30;
        // largest root r with r^5 <= sq, so that sq * r = base^2.4
        lo_r = 64'd0;
        hi_r = ONE_Q30 + 64'd1;
        while (hi_r - lo_r > 64'd1) begin
            probe = (lo_r + hi_r) >> 1;
            if (fx_fifth(probe) <= sq) begin
                lo_r = probe;
            end else begin
                hi_r = probe;
            end
        end
        l30 = (sq * lo_r + HALF_Q30) >> 30;
        return stx_pkg::LIN_W'((l30 * 64'd6553600 + HALF_Q30) >> 30);
    endfunction

    function automatic logic [stx_pkg::OUT_W-1:0] scale_row(input logic [63:0] sum);
        logic [63:0] q;
        q = (sum + 64'd640000) / 64'd1280000;
        if (q > 64'd65535) begin
            q = 64'd65535;
        end
        return stx_pkg::OUT_W'(q);
    endfunction

    function automatic xyz_px_t xyz_of_pixel(
        input logic [7:0] r, input logic [7:0] g, input logic [7:0] b, input logic [7:0] a
    );
        xyz_px_t     px;
        logic [63:0] lr;
        logic [63:0] lg;
        logic [63:0] lb;
        lr = 64'(gamma_lut[r]);
        lg = 64'(gamma_lut[g]);
        lb = 64'(gamma_lut[b]);
        px.x     = scale_row(KX_R * lr + KX_G * lg + KX_B * lb);
        px.y     = scale_row(KY_R * lr + KY_G * lg + KY_B * lb);
        px.z     = scale_row(KZ_R * lr + KZ_G * lg + KZ_B * lb);
        px.alpha = a;
        return px;
    endfunction

    task automatic flag_mismatch(input string what, input int got, input int want);
        $display("%0t: ERROR %s: got %0d, expected %0d", $realtime, what, got, want);
        o_err_count++;
    endtask

    initial begin
        o_err_count = 0;
        o_pending   = 0;
        for (int i = 0; i < 256; i++) begin
            gamma_lut[i] = linear_of_code(i);
        end
    end

    always @(posedge i_clk) begin
        xyz_px_t want;
        if (i_rst_n) begin
            // compare before queuing, so a same-edge transfer cannot match itself
            if (i_valid) begin
                if (xyz_expected.size() == 0) begin
                    flag_mismatch("result with no pixel pending, x", int'(i_x_out), -1);
                end else begin
                    want = xyz_expected.pop_front();
                    if (i_x_out !== want.x) flag_mismatch("x_out", int'(i_x_out), int'(want.x));
                    if (i_y_out !== want.y) flag_mismatch("y_out", int'(i_y_out), int'(want.y));
                    if (i_z_out !== want.z) flag_mismatch("z_out", int'(i_z_out), int'(want.z));
                    if (i_alpha_out !== want.alpha) begin
                        flag_mismatch("alpha_out", int'(i_alpha_out), int'(want.alpha));
                    end
                end
            end
            if (i_start && !i_busy) begin
                xyz_expected.push_back(xyz_of_pixel(i_red, i_green, i_blue, i_alpha_in));
            end
        end
        o_pending = xyz_expected.size();
    end

endmodule

// ----- tb/sv/srgb_to_xyz_converter_unit_tb.sv -----
// Top of the sRGB to XYZ converter testbench: clock, reset, pixel stimulus in
// bursts, watchdog and verdict. Depends on stx_pkg, the converter and xyz_pixel_checker.
`timescale 1ns / 1ps

module srgb_to_xyz_converter_unit_tb;

    localparam int RANDOM_PIXELS = 1150;
    localparam int STALL_LIMIT   = 1000;
    localparam int TAIL_CYCLES   = 12;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       start;
    logic                       busy;
    logic [stx_pkg::BYTE_W-1:0] i_red;
    logic [stx_pkg::BYTE_W-1:0] i_green;
    logic [stx_pkg::BYTE_W-1:0] i_blue;
    logic [stx_pkg::BYTE_W-1:0] i_alpha_in;
    logic                       o_valid;
    logic [stx_pkg::OUT_W-1:0]  o_x_out;
    logic [stx_pkg::OUT_W-1:0]  o_y_out;
    logic [stx_pkg::OUT_W-1:0]  o_z_out;
    logic [stx_pkg::BYTE_W-1:0] o_alpha_out;
    int                         err_count;
    int                         pending;
    int                         quiet_cycles;

    srgb_to_xyz_converter_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_red       (i_red),
        .i_green     (i_green),
        .i_blue      (i_blue),
        .i_alpha_in  (i_alpha_in),
        .o_valid     (o_valid),
        .o_x_out     (o_x_out),
        .o_y_out     (o_y_out),
        .o_z_out     (o_z_out),
        .o_alpha_out (o_alpha_out)
    );

    xyz_pixel_checker u_xyz_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_busy      (busy),
        .i_red       (i_red),
        .i_green     (i_green),
        .i_blue      (i_blue),
        .i_alpha_in  (i_alpha_in),
        .i_valid     (o_valid),
        .i_x_out     (o_x_out),
        .i_y_out     (o_y_out),
        .i_z_out     (o_z_out),
        .i_alpha_out (o_alpha_out),
        .o_err_count (err_count),
        .o_pending   (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // End the run if neither channel moves for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_pixel(
        input logic [7:0] r, input logic [7:0] g, input logic [7:0] b, input logic [7:0] a
    );
        @(negedge i_clk);
        start      <= 1'b1;
        i_red      <= r;
        i_green    <= g;
        i_blue     <= b;
        i_alpha_in <= a;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic hold_idle(input int cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            start      <= 1'b0;
            i_red      <= 8'($urandom);
            i_green    <= 8'($urandom);
            i_blue     <= 8'($urandom);
            i_alpha_in <= 8'($urandom);
        end
    endtask

    task automatic drain_results();
        hold_idle(1);
        wait (pending == 0);
    endtask

    // Mostly uniform codes, with extra weight around the segment boundary and the ends.
    function automatic logic [7:0] pick_code();
        int mode;
        mode = $urandom_range(0, 19);
        if (mode < 14) begin
            return 8'($urandom);
        end else if (mode < 17) begin
            return 8'($urandom_range(0, 20));
        end else if (mode < 18) begin
            return 8'($urandom_range(240, 255));
        end else begin
            return ($urandom_range(0, 1) == 0) ? 8'd0 : 8'd255;
        end
    endfunction

    initial begin
        int sent;
        int burst;
        start        = 1'b0;
        i_rst_n      = 1'b0;
        i_red        = '0;
        i_green      = '0;
        i_blue       = '0;
        i_alpha_in   = '0;
        quiet_cycles = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // black, white, primaries, segment boundary, alpha extremes
        send_pixel(8'd0,   8'd0,   8'd0,   8'd0);
        send_pixel(8'd255, 8'd255, 8'd255, 8'd255);
        send_pixel(8'd255, 8'd0,   8'd0,   8'd128);
        send_pixel(8'd0,   8'd255, 8'd0,   8'd1);
        send_pixel(8'd0,   8'd0,   8'd255, 8'd254);
        send_pixel(8'd10,  8'd10,  8'd10,  8'd10);
        send_pixel(8'd11,  8'd11,  8'd11,  8'd11);
        send_pixel(8'd10,  8'd11,  8'd12,  8'hAA);
        send_pixel(8'd1,   8'd1,   8'd1,   8'h55);
        send_pixel(8'd254, 8'd254, 8'd254, 8'hFF);
        hold_idle(3);
        send_pixel(8'hAA,  8'h55,  8'hAA,  8'h55);
        send_pixel(8'h55,  8'hAA,  8'h55,  8'hAA);
        send_pixel(8'd255, 8'd255, 8'd0,   8'd0);
        send_pixel(8'd0,   8'd255, 8'd255, 8'd255);
        send_pixel(8'd255, 8'd0,   8'd255, 8'd7);
        send_pixel(8'd128, 8'd128, 8'd128, 8'd128);
        send_pixel(8'd11,  8'd0,   8'd10,  8'd0);
        send_pixel(8'd9,   8'd2,   8'd5,   8'd200);
        drain_results();

        sent = 0;
        while (sent < RANDOM_PIXELS) begin
            burst = $urandom_range(1, 40);
            repeat (burst) begin
                send_pixel(pick_code(), pick_code(), pick_code(), 8'($urandom));
                sent++;
            end
            if (sent >= RANDOM_PIXELS / 2 && sent - burst < RANDOM_PIXELS / 2) begin
                drain_results();
            end else if ($urandom_range(0, 3) != 0) begin
                hold_idle($urandom_range(1, 12));
            end
        end
        hold_idle(1);

        wait (pending == 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ----- srgb_to_xyz_converter_unit.f -----
design/stx_pkg.sv
design/stx_linearize.sv
design/stx_matrix.sv
design/srgb_to_xyz_converter_unit.sv
tb/sv/xyz_pixel_checker.sv
tb/sv/srgb_to_xyz_converter_unit_tb.sv
